### rtl/rdst_pkg.sv
// Shared widths, codes and types for the row damage span tracker.
package rdst_pkg;

    // Field widths fixed by the register and beat layouts.
    localparam int SPAN_W     = 11;
    localparam int ROWREG_W   = 9;
    localparam int COORD_W    = 13;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    // Default grid limits for the top-level parameters.
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 256;

    // Register values after reset.
    localparam logic [SPAN_W-1:0]   RESET_COLS = 11'd80;
    localparam logic [ROWREG_W-1:0] RESET_ROWS = 9'd25;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 4'd1;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_CELL  = 2'd0,
        REQ_RECT  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_QUERY = 2'd3
    } req_kind_t;

    // One stored row span, high exclusive.
    typedef struct packed {
        logic [SPAN_W-1:0] low;
        logic [SPAN_W-1:0] high;
    } span_t;

endpackage

### rtl/rdst_if.sv
// Handshake interfaces for the request, response and configuration channels.
interface rdst_req_if import rdst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [DIM_W-1:0]          rect_w;
    logic [DIM_W-1:0]          rect_h;

    modport source (output valid, req_type, pos_x, pos_y, rect_w, rect_h, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, rect_w, rect_h, output ready);
endinterface

interface rdst_rsp_if import rdst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SPAN_W-1:0] span_low;
    logic [SPAN_W-1:0] span_high;
    logic              span_empty;
    logic              any_damage;
    logic              status;

    modport source (output valid, span_low, span_high, span_empty, any_damage, status,
                    input ready);
    modport sink   (input valid, span_low, span_high, span_empty, any_damage, status,
                    output ready);
endinterface

interface rdst_cfg_if import rdst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rdst_span_mem.sv
// Span memory: one write port and one read port with registered read data.
module rdst_span_mem import rdst_pkg::*; #(
    parameter int DEPTH  = MAX_ROWS_DEF,
    parameter int ADDR_W = (MAX_ROWS_DEF > 1) ? $clog2(MAX_ROWS_DEF) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  span_t             wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output span_t             rd_data
);

    span_t mem [DEPTH];
    span_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/row_damage_span_tracker.sv
// Every request gives one result beat unless a size write cuts it short; a clear all empties every row.
// Throughput: one request at a time; a rectangle walks one row a cycle through the span memory.
// Reset and every write to screen_cols or screen_rows start a sweep of the span memory that
// marks all rows in use dirty over their full width; no request is taken during the sweep.
// A request is taken while the previous result beat still waits in the output register.
module row_damage_span_tracker import rdst_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    rdst_req_if.sink   req,
    rdst_rsp_if.source rsp,
    rdst_cfg_if.sink   cfg
);

    localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(MAX_ROWS - 1);
    localparam int CLIP_W = COORD_W + 2;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_PREP,
        S_WB,
        S_QRD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [SPAN_W-1:0]   cols_reg, cols_next;
    logic [ROWREG_W-1:0] rows_reg, rows_next;
    logic [ROWREG_W-1:0] dirty_cnt_reg, dirty_cnt_next;

    logic [ROW_IDX_W-1:0] sweep_row_reg, sweep_row_next;
    logic                 sweep_fill_reg, sweep_fill_next;
    logic                 sweep_reply_reg, sweep_reply_next;

    req_kind_t                 kind_reg, kind_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic [DIM_W-1:0]          w_reg, w_next;
    logic [DIM_W-1:0]          h_reg, h_next;

    logic [ROW_IDX_W-1:0] cur_row_reg, cur_row_next;
    logic [ROW_IDX_W-1:0] last_row_reg, last_row_next;
    logic [SPAN_W-1:0]    lo_reg, lo_next;
    logic [SPAN_W-1:0]    hi_reg, hi_next;

    logic              status_reg, status_next;
    logic [SPAN_W-1:0] q_low_reg, q_low_next;
    logic [SPAN_W-1:0] q_high_reg, q_high_next;
    logic              q_empty_reg, q_empty_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [SPAN_W-1:0] rsp_low_reg, rsp_low_next;
    logic [SPAN_W-1:0] rsp_high_reg, rsp_high_next;
    logic              rsp_empty_reg, rsp_empty_next;
    logic              rsp_damage_reg, rsp_damage_next;
    logic              rsp_status_reg, rsp_status_next;

    logic [SPAN_W-1:0]   used_cols;
    logic [ROWREG_W-1:0] used_rows;

    logic signed [CLIP_W-1:0] xs, ys, ws, hs, x_end, y_end;
    logic signed [CLIP_W-1:0] cols_s, rows_s;
    logic signed [CLIP_W-1:0] left, right, top, bottom;
    logic                     rect_hit, cell_hit, query_hit;

    logic                 mem_we;
    logic [ROW_IDX_W-1:0] mem_wr_addr;
    span_t                mem_wr_data;
    logic [ROW_IDX_W-1:0] mem_rd_addr;
    span_t                mem_rd_data;
    logic                 cfg_hit;

    // Register values above the grid limits are used as the limits.
    assign used_cols = (int'(cols_reg) > MAX_COLS) ? SPAN_W'(MAX_COLS) : cols_reg;
    assign used_rows = (int'(rows_reg) > MAX_ROWS) ? ROWREG_W'(MAX_ROWS) : rows_reg;

    // Clip the captured request against the grid.
    assign xs     = {{2{x_reg[COORD_W-1]}}, x_reg};
    assign ys     = {{2{y_reg[COORD_W-1]}}, y_reg};
    assign ws     = {2'b00, w_reg};
    assign hs     = {2'b00, h_reg};
    assign x_end  = xs + ws;
    assign y_end  = ys + hs;
    assign cols_s = {{(CLIP_W - SPAN_W){1'b0}}, used_cols};
    assign rows_s = {{(CLIP_W - ROWREG_W){1'b0}}, used_rows};
    assign left   = (xs < 0) ? '0 : xs;
    assign right  = (x_end > cols_s) ? cols_s : x_end;
    assign top    = (ys < 0) ? '0 : ys;
    assign bottom = (y_end > rows_s) ? rows_s : y_end;

    assign rect_hit  = (left < right) && (top < bottom);
    assign query_hit = (ys >= 0) && (ys < rows_s);
    assign cell_hit  = (xs >= 0) && (xs < cols_s) && query_hit;

    assign cfg_hit = cfg.valid && cfg.ready &&
                     ((cfg.index == CFG_SCREEN_COLS) || (cfg.index == CFG_SCREEN_ROWS));

    // Next-state and memory port logic.
    always_comb
    begin
        state_next       = state_reg;
        cols_next        = cols_reg;
        rows_next        = rows_reg;
        dirty_cnt_next   = dirty_cnt_reg;
        sweep_row_next   = sweep_row_reg;
        sweep_fill_next  = sweep_fill_reg;
        sweep_reply_next = sweep_reply_reg;
        kind_next        = kind_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        cur_row_next     = cur_row_reg;
        last_row_next    = last_row_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        status_next      = status_reg;
        q_low_next       = q_low_reg;
        q_high_next      = q_high_reg;
        q_empty_next     = q_empty_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_low_next     = rsp_low_reg;
        rsp_high_next    = rsp_high_reg;
        rsp_empty_next   = rsp_empty_reg;
        rsp_damage_next  = rsp_damage_reg;
        rsp_status_next  = rsp_status_reg;

        mem_we      = 1'b0;
        mem_wr_addr = cur_row_reg;
        mem_wr_data = '0;
        mem_rd_addr = cur_row_reg;

        // The waiting result beat leaves once the sink takes it.
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                // Rewrite one row a cycle, full width for rows in use or empty.
                mem_we      = 1'b1;
                mem_wr_addr = sweep_row_reg;
                if (sweep_fill_reg && (32'(sweep_row_reg) < 32'(used_rows)))
                begin
                    mem_wr_data.high = used_cols;
                end
                if (sweep_fill_reg && (used_cols != '0))
                begin
                    dirty_cnt_next = used_rows;
                end
                else
                begin
                    dirty_cnt_next = '0;
                end
                if (sweep_row_reg == LAST_ROW)
                begin
                    sweep_row_next = '0;
                    state_next     = sweep_reply_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    sweep_row_next = sweep_row_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next    = req_kind_t'(req.req_type);
                    x_next       = req.pos_x;
                    y_next       = req.pos_y;
                    w_next       = req.rect_w;
                    h_next       = req.rect_h;
                    status_next  = 1'b0;
                    q_low_next   = '0;
                    q_high_next  = '0;
                    q_empty_next = 1'b0;
                    state_next   = S_PREP;
                end
            end

            S_PREP:
            begin
                case (kind_reg)
                    REQ_CELL:
                    begin
                        if (cell_hit)
                        begin
                            cur_row_next  = ys[ROW_IDX_W-1:0];
                            last_row_next = ys[ROW_IDX_W-1:0];
                            lo_next       = xs[SPAN_W-1:0];
                            hi_next       = SPAN_W'(xs + 1);
                            mem_rd_addr   = ys[ROW_IDX_W-1:0];
                            state_next    = S_WB;
                        end
                        else
                        begin
                            status_next = 1'b1;
                            state_next  = S_DONE;
                        end
                    end
                    REQ_RECT:
                    begin
                        if (rect_hit)
                        begin
                            cur_row_next  = top[ROW_IDX_W-1:0];
                            last_row_next = ROW_IDX_W'(bottom - 1);
                            lo_next       = left[SPAN_W-1:0];
                            hi_next       = right[SPAN_W-1:0];
                            mem_rd_addr   = top[ROW_IDX_W-1:0];
                            state_next    = S_WB;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        sweep_row_next   = '0;
                        sweep_fill_next  = 1'b0;
                        sweep_reply_next = 1'b1;
                        state_next       = S_SWEEP;
                    end
                    REQ_QUERY:
                    begin
                        if (query_hit)
                        begin
                            mem_rd_addr = ys[ROW_IDX_W-1:0];
                            state_next  = S_QRD;
                        end
                        else
                        begin
                            status_next = 1'b1;
                            state_next  = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_WB:
            begin
                // Widen the row just read and write it back; read the next row meanwhile.
                mem_we      = 1'b1;
                mem_wr_addr = cur_row_reg;
                if (mem_rd_data.high <= mem_rd_data.low)
                begin
                    mem_wr_data.low  = lo_reg;
                    mem_wr_data.high = hi_reg;
                    dirty_cnt_next   = dirty_cnt_reg + 1'b1;
                end
                else
                begin
                    mem_wr_data.low  = (lo_reg < mem_rd_data.low) ? lo_reg : mem_rd_data.low;
                    mem_wr_data.high = (hi_reg > mem_rd_data.high) ? hi_reg
                                                                    : mem_rd_data.high;
                end
                if (cur_row_reg == last_row_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                    mem_rd_addr  = cur_row_reg + 1'b1;
                end
            end

            S_QRD:
            begin
                q_low_next   = mem_rd_data.low;
                q_high_next  = mem_rd_data.high;
                q_empty_next = (mem_rd_data.high <= mem_rd_data.low);
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                // Load the output register once it is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_low_next    = q_low_reg;
                    rsp_high_next   = q_high_reg;
                    rsp_empty_next  = q_empty_reg;
                    rsp_damage_next = (dirty_cnt_reg != '0);
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A size write restarts the full-width sweep.
        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_SCREEN_COLS)
            begin
                cols_next = cfg.data[SPAN_W-1:0];
            end
            else if (cfg.index == CFG_SCREEN_ROWS)
            begin
                rows_next = cfg.data[ROWREG_W-1:0];
            end
        end
        if (cfg_hit)
        begin
            sweep_row_next   = '0;
            sweep_fill_next  = 1'b1;
            sweep_reply_next = 1'b0;
            state_next       = S_SWEEP;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            cols_reg        <= RESET_COLS;
            rows_reg        <= RESET_ROWS;
            dirty_cnt_reg   <= '0;
            sweep_row_reg   <= '0;
            sweep_fill_reg  <= 1'b1;
            sweep_reply_reg <= 1'b0;
            kind_reg        <= REQ_CELL;
            x_reg           <= '0;
            y_reg           <= '0;
            w_reg           <= '0;
            h_reg           <= '0;
            cur_row_reg     <= '0;
            last_row_reg    <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            status_reg      <= 1'b0;
            q_low_reg       <= '0;
            q_high_reg      <= '0;
            q_empty_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_low_reg     <= '0;
            rsp_high_reg    <= '0;
            rsp_empty_reg   <= 1'b0;
            rsp_damage_reg  <= 1'b0;
            rsp_status_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cols_reg        <= cols_next;
            rows_reg        <= rows_next;
            dirty_cnt_reg   <= dirty_cnt_next;
            sweep_row_reg   <= sweep_row_next;
            sweep_fill_reg  <= sweep_fill_next;
            sweep_reply_reg <= sweep_reply_next;
            kind_reg        <= kind_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
            w_reg           <= w_next;
            h_reg           <= h_next;
            cur_row_reg     <= cur_row_next;
            last_row_reg    <= last_row_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            status_reg      <= status_next;
            q_low_reg       <= q_low_next;
            q_high_reg      <= q_high_next;
            q_empty_reg     <= q_empty_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_low_reg     <= rsp_low_next;
            rsp_high_reg    <= rsp_high_next;
            rsp_empty_reg   <= rsp_empty_next;
            rsp_damage_reg  <= rsp_damage_next;
            rsp_status_reg  <= rsp_status_next;
        end
    end

    // Span memory.
    rdst_span_mem #(
        .DEPTH  (MAX_ROWS),
        .ADDR_W (ROW_IDX_W)
    ) u_span_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Channel outputs.
    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.span_low   = rsp_low_reg;
    assign rsp.span_high  = rsp_high_reg;
    assign rsp.span_empty = rsp_empty_reg;
    assign rsp.any_damage = rsp_damage_reg;
    assign rsp.status     = rsp_status_reg;

`ifndef SYNTHESIS
    // The dirty row count never exceeds the rows in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SWEEP) |-> (dirty_cnt_reg <= used_rows))
        else $error("dirty row count exceeds rows in use");

    // A size write always starts a sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (state_reg == S_SWEEP))
        else $error("size write did not start a sweep");

    // A widened span written back is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> (mem_wr_data.low < mem_wr_data.high))
        else $error("empty span written back");

    // The walk stays within the rows in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> (32'(cur_row_reg) < 32'(used_rows)))
        else $error("row walk left the grid");

    // A result beat only appears after the completion state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result beat raised outside completion");
`endif

endmodule
